/* rtl/core/bsr_pkg.sv */
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the bitmap shape rasterizer.
// ----------------------------------------------------------------------------
package bsr_pkg;

  // Command codes carried on the mode port.
  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_RECT  = 3'd1;
  localparam logic [2:0] MODE_LINE  = 3'd2;
  localparam logic [2:0] MODE_CIRC  = 3'd3;
  localparam logic [2:0] MODE_TRI   = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  // Internal signed coordinate width; holds a sum of two 8-bit fields.
  localparam int CRD_W  = 11;
  // Fraction bits of the line position and step.
  localparam int FRAC_W = 16;
  // Line position width, Q9.16 plus one guard bit.
  localparam int POS_W  = 26;
  // Divider numerator (8-bit magnitude shifted by the fraction) and quotient.
  localparam int DIV_N_W = 8 + FRAC_W;
  localparam int DIV_Q_W = FRAC_W + 1;

  // Access strobes from the sequencer to the canvas memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage

/* rtl/core/bsr_canvas.sv */
// ----------------------------------------------------------------------------
// bsr_canvas
// Canvas store: one word per row, one bit per column, registered read.
// ----------------------------------------------------------------------------
module bsr_canvas #(
  parameter int ROWS = 20,
  parameter int COLS = 40,
  parameter int RAW  = 5
) (
  input  logic                 clk,
  input  bsr_pkg::mem_cmd_t    cmd,
  input  logic [RAW-1:0]       rd_addr,
  input  logic [RAW-1:0]       wr_addr,
  input  logic [COLS-1:0]      wr_data,
  output logic [COLS-1:0]      rd_data
);
  import bsr_pkg::*;

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/bsr_div.sv */
// ----------------------------------------------------------------------------
// bsr_div
// Restoring divider, one quotient bit per cycle, for the line step size.
// ----------------------------------------------------------------------------
module bsr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bsr_pkg::DIV_N_W-1:0] num,
  input  logic [7:0]                  den,
  output logic [bsr_pkg::DIV_Q_W-1:0] quo,
  output logic                        done
);
  import bsr_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               running;
  logic [CNT_W-1:0]   cnt;
  logic [7:0]         rem;
  logic [7:0]         den_q;
  logic [DIV_N_W-1:0] nq;
  logic [8:0]         trial;
  logic               fits;

  // The divisor is held from start, since the command inputs move on after
  // the beat is taken.
  assign trial = {rem, nq[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign quo   = nq[DIV_Q_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq    <= num;
      rem   <= '0;
      den_q <= den;
    end else if (running) begin
      rem <= fits ? 8'(trial - {1'b0, den_q}) : trial[7:0];
      nq  <= {nq[DIV_N_W-2:0], fits};
    end
  end

endmodule

/* rtl/core/bitmap_shape_rasterizer.sv */
// ----------------------------------------------------------------------------
// bitmap_shape_rasterizer
// One-bit canvas with clear, rectangle, line, ring circle, triangle and read.
// ----------------------------------------------------------------------------
// Reset: a clearing pass writes CANVAS_ROWS zero rows; busy is high meanwhile.
// Clear reruns that sweep. Rectangle and triangle read and write back each
// canvas row touched and pass over a row off the canvas. A line first waits
// for the step dividers (not for a single point), then places each point and
// reads and writes its row. A circle squares, tests, reads and writes each row.
// A read beat follows the issue and result states; the receiver cannot stall.

module bitmap_shape_rasterizer #(
  parameter int CANVAS_ROWS = 20,
  parameter int CANVAS_COLS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [7:0] coord_a,
  input  logic [7:0] coord_b,
  input  logic [7:0] coord_c,
  input  logic [7:0] coord_d,
  output logic       valid,
  output logic       pixel_set
);
  import bsr_pkg::*;

  localparam int RAW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int CAW = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
  localparam logic signed [CRD_W-1:0] ROWS_S = CRD_W'(CANVAS_ROWS);
  localparam logic signed [CRD_W-1:0] COLS_S = CRD_W'(CANVAS_COLS);

  // Sequencer states.
  localparam logic [3:0] S_INIT = 4'd0;  // zero sweep after reset or clear
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;  // read one row of a span or circle
  localparam logic [3:0] S_WR   = 4'd3;  // merge the mask and write back
  localparam logic [3:0] S_LDIV = 4'd4;  // wait for the line step division
  localparam logic [3:0] S_LPT  = 4'd5;  // place the next line point
  localparam logic [3:0] S_CSQ  = 4'd6;  // square the circle row offset
  localparam logic [3:0] S_CCOL = 4'd7;  // test one circle cell per cycle
  localparam logic [3:0] S_PRD  = 4'd8;  // pixel read issue
  localparam logic [3:0] S_POUT = 4'd9;  // pixel result beat

  logic [3:0] state;
  logic [2:0] op;

  // Span walk: rows cur_row..last_row, columns col_lo..col_hi.
  logic signed [CRD_W-1:0] cur_row, last_row, col_lo, col_hi;
  logic [CANVAS_COLS-1:0]  mask;

  // Line position and step, Q9.16.
  logic signed [POS_W-1:0] pos_r, pos_c, inc_r, inc_c;
  logic [8:0]              pts_left;
  logic                    neg_r, neg_c;

  // Circle test operands.
  logic [7:0]     rad;
  logic [14:0]    rad2;
  logic [16:0]    dr2;
  logic [CAW-1:0] ccol;

  // Held circle center.
  logic signed [CRD_W-1:0] a_hold, b_hold;

  // Canvas memory port.
  mem_cmd_t               mcmd;
  logic [CANVAS_COLS-1:0] rd_data, wr_data;

  // Divider operands.
  logic                 div_start, div_done, div_done_c;
  logic [DIV_Q_W-1:0]   quo_r, quo_c;

  // Field extensions and line setup terms.
  logic signed [CRD_W-1:0] a_x, b_x, c_x, d_x;
  logic signed [8:0]       ldr, ldc;
  logic [7:0]              mag_r, mag_c, steps;

  assign a_x = CRD_W'($signed(coord_a));
  assign b_x = CRD_W'($signed(coord_b));
  assign c_x = CRD_W'($signed(coord_c));
  assign d_x = CRD_W'($signed(coord_d));

  assign ldr   = $signed({coord_c[7], coord_c}) - $signed({coord_a[7], coord_a});
  assign ldc   = $signed({coord_d[7], coord_d}) - $signed({coord_b[7], coord_b});
  assign mag_r = ldr[8] ? 8'(-ldr) : ldr[7:0];
  assign mag_c = ldc[8] ? 8'(-ldc) : ldc[7:0];
  assign steps = (mag_r > mag_c) ? mag_r : mag_c;

  assign busy = (state != S_IDLE);

  logic accept;
  assign accept = start && !busy;

  assign div_start = accept && (mode == MODE_LINE) && (steps != 8'd0);

  bsr_div u_div_r (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({mag_r, FRAC_W'(0)}),
    .den   (steps),
    .quo   (quo_r),
    .done  (div_done)
  );

  bsr_div u_div_c (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({mag_c, FRAC_W'(0)}),
    .den   (steps),
    .quo   (quo_c),
    .done  (div_done_c)
  );

  // Row and column on the canvas.
  logic row_on, col_on;
  assign row_on = (cur_row >= 0) && (cur_row < ROWS_S);
  assign col_on = (col_lo >= 0) && (col_lo < COLS_S);

  // Column mask of the current span row; each bit is compared on its own.
  logic [CANVAS_COLS-1:0] span_mask;
  always_comb begin
    for (int j = 0; j < CANVAS_COLS; j++) begin
      span_mask[j] = ($signed(CRD_W'(j)) >= col_lo) && ($signed(CRD_W'(j)) <= col_hi);
    end
  end

  // Line point truncated toward zero: a negative position is rounded up.
  logic signed [POS_W-1:0] adj_r, adj_c;
  assign adj_r = pos_r[POS_W-1] ? pos_r + POS_W'(16'hFFFF) : pos_r;
  assign adj_c = pos_c[POS_W-1] ? pos_c + POS_W'(16'hFFFF) : pos_c;

  // Ring test for the current circle cell: |d^2 - r^2| <= r.
  logic signed [CRD_W-1:0]   dr, dc;
  logic signed [2*CRD_W-1:0] dr_sq, dc_sq;
  logic [17:0]               dsum;
  logic signed [18:0]        ring_diff, rad_x;
  logic                      ring_hit;

  assign dr        = cur_row - a_hold;
  assign dc        = $signed(CRD_W'(ccol)) - b_hold;
  assign dr_sq     = dr * dr;
  assign dc_sq     = dc * dc;
  assign dsum      = {1'b0, dr2} + {1'b0, dc_sq[16:0]};
  assign rad_x     = 19'(rad);
  assign ring_diff = $signed({1'b0, dsum}) - $signed({4'b0, rad2});
  assign ring_hit  = (ring_diff <= rad_x) && (ring_diff >= -rad_x);

  // Memory strobes and write data.
  always_comb begin
    mcmd.rd_en = ((state == S_RD) || (state == S_PRD)) && row_on;
    mcmd.wr_en = (state == S_INIT) || (state == S_WR);
    wr_data    = (state == S_INIT) ? '0 : (rd_data | mask);
  end

  bsr_canvas #(
    .ROWS (CANVAS_ROWS),
    .COLS (CANVAS_COLS),
    .RAW  (RAW)
  ) u_canvas (
    .clk     (clk),
    .cmd     (mcmd),
    .rd_addr (cur_row[RAW-1:0]),
    .wr_addr (cur_row[RAW-1:0]),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cur_row <= '0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          if (cur_row == ROWS_S - 1) begin
            state <= S_IDLE;
          end
          cur_row <= cur_row + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            priority case (mode)
              MODE_CLEAR: begin
                cur_row <= '0;
                state   <= S_INIT;
              end
              MODE_RECT: begin
                cur_row <= a_x;
                if ($signed(coord_d) > 0) begin
                  state <= S_RD;
                end
              end
              MODE_TRI: begin
                cur_row <= a_x;
                if ($signed(coord_c) > 0) begin
                  state <= S_RD;
                end
              end
              MODE_LINE: begin
                state <= (steps == 8'd0) ? S_LPT : S_LDIV;
              end
              MODE_CIRC: begin
                cur_row <= '0;
                if (!coord_c[7]) begin
                  state <= S_CSQ;
                end
              end
              MODE_READ: begin
                cur_row <= a_x;
                state   <= S_PRD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LDIV: begin
          if (div_done) begin
            state <= S_LPT;
          end
        end
        S_LPT: begin
          cur_row <= {adj_r[POS_W-1], adj_r[POS_W-1:FRAC_W]};
          state   <= S_RD;
        end
        S_CSQ: begin
          state <= S_CCOL;
        end
        S_CCOL: begin
          if (ccol == CAW'(CANVAS_COLS - 1)) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (row_on) begin
            state <= S_WR;
          end else if (cur_row >= last_row) begin
            state <= ((op == MODE_LINE) && (pts_left != 9'd0)) ? S_LPT : S_IDLE;
          end else begin
            cur_row <= cur_row + 1'b1;
          end
        end
        S_WR: begin
          if (op == MODE_CIRC) begin
            if (cur_row == ROWS_S - 1) begin
              state <= S_IDLE;
            end else begin
              cur_row <= cur_row + 1'b1;
              state   <= S_CSQ;
            end
          end else if (cur_row >= last_row) begin
            state <= ((op == MODE_LINE) && (pts_left != 9'd0)) ? S_LPT : S_IDLE;
          end else begin
            cur_row <= cur_row + 1'b1;
            state   <= S_RD;
          end
        end
        S_PRD: begin
          state <= S_POUT;
        end
        S_POUT: begin
          valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= mode;
      a_hold <= a_x;
      b_hold <= b_x;
      rad    <= coord_c;
      rad2   <= 15'($signed(coord_c) * $signed(coord_c));
      col_lo <= b_x;
      neg_r  <= ldr[8];
      neg_c  <= ldc[8];
      pos_r  <= {{(POS_W - 8 - FRAC_W){coord_a[7]}}, coord_a, FRAC_W'(0)};
      pos_c  <= {{(POS_W - 8 - FRAC_W){coord_b[7]}}, coord_b, FRAC_W'(0)};
      inc_r  <= '0;
      inc_c  <= '0;
      pts_left <= {1'b0, steps} + 9'd1;
      if (mode == MODE_RECT) begin
        last_row <= a_x + d_x - 1'b1;
        col_hi   <= b_x + c_x - 1'b1;
      end else begin
        last_row <= a_x + c_x - 1'b1;
        col_hi   <= b_x;
      end
    end
    unique case (state)
      S_LDIV: begin
        inc_r <= neg_r ? -POS_W'(quo_r) : POS_W'(quo_r);
        inc_c <= neg_c ? -POS_W'(quo_c) : POS_W'(quo_c);
      end
      S_LPT: begin
        last_row <= {adj_r[POS_W-1], adj_r[POS_W-1:FRAC_W]};
        col_lo   <= {adj_c[POS_W-1], adj_c[POS_W-1:FRAC_W]};
        col_hi   <= {adj_c[POS_W-1], adj_c[POS_W-1:FRAC_W]};
        pos_r    <= pos_r + inc_r;
        pos_c    <= pos_c + inc_c;
        pts_left <= pts_left - 1'b1;
      end
      S_CSQ: begin
        dr2  <= dr_sq[16:0];
        ccol <= '0;
        mask <= '0;
      end
      S_CCOL: begin
        mask[ccol] <= ring_hit;
        ccol       <= ccol + 1'b1;
      end
      S_RD: begin
        if (op != MODE_CIRC) begin
          mask <= span_mask;
        end
      end
      S_WR: begin
        // Each triangle row is one column wider than the one above it.
        if ((op == MODE_TRI) && (cur_row < last_row)) begin
          col_hi <= col_hi + 1'b1;
        end
      end
      S_POUT: begin
        pixel_set <= row_on && col_on && rd_data[col_lo[CAW-1:0]];
      end
      default: begin
      end
    endcase
    // The triangle also widens on rows that lie off the canvas.
    if ((state == S_RD) && !row_on && (op == MODE_TRI) && (cur_row < last_row)) begin
      col_hi <= col_hi + 1'b1;
    end
  end

  // The canvas is never read and written in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(mcmd.rd_en && mcmd.wr_en))
    else $error("canvas read and write in one cycle");

  // A result beat lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result beat longer than one cycle");

  // A result beat only follows a pixel read command.
  assert property (@(posedge clk) disable iff (rst) valid |-> ($past(op) == MODE_READ))
    else $error("result beat without a read command");

  // Both step dividers finish together.
  assert property (@(posedge clk) disable iff (rst) div_done == div_done_c)
    else $error("line dividers out of step");

endmodule

/* test/tb_bitmap_shape_rasterizer.sv */
// ----------------------------------------------------------------------------
// tb_bitmap_shape_rasterizer
// Self-checking bench for the bitmap shape rasterizer. A driver feeds command
// beats from a queue and a shadow canvas predicts every pixel read; a monitor
// compares each read beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bitmap_shape_rasterizer;
  import bsr_pkg::*;

  localparam int ROWS = 20;
  localparam int COLS = 40;
  // Codes outside the command set; the block must ignore them.
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  // A circle walks the whole canvas, and this is still far beyond any legal
  // silence on both sides.
  localparam int STALL_LIMIT = 5000;
  localparam int QUIET_TAIL  = 100;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
  } cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] mode = MODE_CLEAR;
  logic [7:0] coord_a = '0, coord_b = '0, coord_c = '0, coord_d = '0;
  logic       valid;
  logic       pixel_set;

  cmd_t pending_cmds[$];
  bit   expected_pixels[$];
  bit   canvas_q [ROWS][COLS];
  int   idle_left = 0;
  int   err_count = 0, n_cmds = 0, n_reads = 0, n_lit = 0, silent = 0;
  int   mode_seen [8];

  bitmap_shape_rasterizer #(.CANVAS_ROWS(ROWS), .CANVAS_COLS(COLS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c), .coord_d(coord_d),
    .valid(valid), .pixel_set(pixel_set)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow canvas. Every shape lands through plot, which drops off-canvas cells
  // on all four sides, so clipping needs no special handling in the shapes.
  // ---------------------------------------------------------------------------
  task automatic plot(input int r, input int c);
    if (r >= 0 && r < ROWS && c >= 0 && c < COLS) canvas_q[r][c] = 1'b1;
  endtask

  // DDA line in Q9.16. SystemVerilog integer division truncates toward zero,
  // which is what both the step and the plotted position need.
  task automatic draw_dda(input int r0, input int c0, input int r1, input int c1);
    int dr, dc, steps, ir, ic, pr, pc;
    dr = r1 - r0;
    dc = c1 - c0;
    steps = (dr < 0 ? -dr : dr) > (dc < 0 ? -dc : dc) ? (dr < 0 ? -dr : dr)
                                                        : (dc < 0 ? -dc : dc);
    ir = 0;
    ic = 0;
    pr = r0 * 65536;
    pc = c0 * 65536;
    if (steps > 0) begin
      ir = (dr * 65536) / steps;
      ic = (dc * 65536) / steps;
    end
    for (int i = 0; i <= steps; i++) begin
      plot(pr / 65536, pc / 65536);
      pr += ir;
      pc += ic;
    end
  endtask

  // Apply one accepted command beat to the shadow canvas; a read queues the
  // pixel the block has to return.
  task automatic apply_cmd(input cmd_t k);
    int a, b, c, d, ring_err;
    bit px;
    a = int'(signed'(k.a));
    b = int'(signed'(k.b));
    c = int'(signed'(k.c));
    d = int'(signed'(k.d));
    mode_seen[k.mode]++;
    case (k.mode)
      MODE_CLEAR: begin
        foreach (canvas_q[r, col]) canvas_q[r][col] = 1'b0;
      end
      MODE_RECT: begin
        for (int r = a; r < a + d; r++)
          for (int col = b; col < b + c; col++) plot(r, col);
      end
      MODE_LINE: draw_dda(a, b, c, d);
      MODE_CIRC: begin
        // Ring test over the whole canvas: |d^2 - r^2| <= r.
        for (int r = 0; r < ROWS; r++)
          for (int col = 0; col < COLS; col++) begin
            ring_err = (r - a) * (r - a) + (col - b) * (col - b) - c * c;
            if ((ring_err < 0 ? -ring_err : ring_err) <= c) plot(r, col);
          end
      end
      MODE_TRI: begin
        for (int i = 0; i < c; i++)
          for (int j = 0; j <= i; j++) plot(a + i, b + j);
      end
      MODE_READ: begin
        px = (a >= 0 && a < ROWS && b >= 0 && b < COLS) ? canvas_q[a][b] : 1'b0;
        expected_pixels.push_back(px);
        n_reads++;
        if (px) n_lit++;
      end
      default: ;
    endcase
  endtask

  function automatic cmd_t mk(input logic [2:0] m, input int a, input int b,
                              input int c, input int d);
    cmd_t k;
    k.mode = m;
    k.a = a[7:0];
    k.b = b[7:0];
    k.c = c[7:0];
    k.d = d[7:0];
    return k;
  endfunction

  // Mostly coordinates that land on or just around the canvas, so shapes
  // actually paint and reads hit painted cells; the rest spans the full field.
  function automatic int near_row();
    return ($urandom_range(9) == 0) ? int'(signed'(8'($urandom))) : $urandom_range(24) - 3;
  endfunction

  function automatic int near_col();
    return ($urandom_range(9) == 0) ? int'(signed'(8'($urandom))) : $urandom_range(45) - 3;
  endfunction

  function automatic int span();
    return ($urandom_range(9) == 0) ? int'(signed'(8'($urandom))) : $urandom_range(16) - 2;
  endfunction

  function automatic cmd_t random_cmd();
    int pick;
    pick = $urandom_range(99);
    // Reads dominate since they are the only visible beats; circles are kept
    // rare because each one walks the whole canvas.
    if (pick < 45) return mk(MODE_READ, near_row(), near_col(), $urandom, $urandom);
    if (pick < 60) return mk(MODE_RECT, near_row(), near_col(), span(), span());
    if (pick < 74) return mk(MODE_LINE, near_row(), near_col(), near_row(), near_col());
    if (pick < 84) return mk(MODE_TRI, near_row(), near_col(), span(), $urandom);
    if (pick < 91) return mk(MODE_CIRC, near_row(), near_col(), span(), $urandom);
    if (pick < 94) return mk(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
    if (pick < 97) return mk($urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7,
                             $urandom, $urandom, $urandom, $urandom);
    // Raw noise on every field, any command.
    return mk(3'($urandom_range(5)), $urandom, $urandom, $urandom, $urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A beat is taken at an edge where start is high and busy is low; the
  // prediction runs at that same edge. The next value of start is settled once
  // per edge so it never gets two assignments in one step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic nxt_start;
    cmd_t k;
    nxt_start = start;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && !busy) begin
        apply_cmd({mode, coord_a, coord_b, coord_c, coord_d});
        n_cmds++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_cmds.size() > 0) begin
          k = pending_cmds.pop_front();
          mode <= k.mode;
          coord_a <= k.a;
          coord_b <= k.b;
          coord_c <= k.c;
          coord_d <= k.d;
          nxt_start = 1'b1;
          // Idle bursts after some beats, but never in the closing stretch.
          if (pending_cmds.size() > QUIET_TAIL && $urandom_range(3) == 0)
            idle_left = $urandom_range(12, 1);
        end
      end
    end
    start <= nxt_start;
  end

  // Monitor: every read beat is matched against the oldest predicted pixel.
  always @(posedge clk) begin
    bit want;
    if (!rst && valid) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected read beat, expected none, actual pixel_set=%0b",
                 $time, pixel_set);
        err_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_set !== want) begin
          $display("%0t: pixel_set mismatch, expected %0b, actual %0b",
                   $time, want, pixel_set);
          err_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a command nor a result moves.
  always @(posedge clk) begin
    if ((start && !busy) || valid || rst) begin
      silent <= 0;
    end else if (silent >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_bitmap_shape_rasterizer: errors");
      $finish;
    end else begin
      silent <= silent + 1;
    end
  end

  initial begin
    // Directed opening: clipping on every side, the degenerate sizes, a
    // zero-length line, field extremes, reads off the canvas and spare codes.
    pending_cmds.push_back(mk(MODE_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(MODE_RECT, -2, -3, 6, 5));
    pending_cmds.push_back(mk(MODE_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(MODE_RECT, 18, 37, 10, 10));
    pending_cmds.push_back(mk(MODE_READ, 19, 39, 0, 0));
    pending_cmds.push_back(mk(MODE_RECT, 5, 5, -1, 3));
    pending_cmds.push_back(mk(MODE_RECT, 5, 5, 3, -128));
    pending_cmds.push_back(mk(MODE_READ, 5, 5, 0, 0));
    pending_cmds.push_back(mk(MODE_LINE, 7, 9, 7, 9));
    pending_cmds.push_back(mk(MODE_READ, 7, 9, 0, 0));
    pending_cmds.push_back(mk(MODE_LINE, -128, -128, 127, 127));
    pending_cmds.push_back(mk(MODE_LINE, 127, -128, -128, 127));
    pending_cmds.push_back(mk(MODE_READ, 10, 10, 0, 0));
    pending_cmds.push_back(mk(MODE_CIRC, 10, 20, -5, 0));
    pending_cmds.push_back(mk(MODE_CIRC, 10, 20, 0, 0));
    pending_cmds.push_back(mk(MODE_CIRC, 10, 20, 127, 0));
    pending_cmds.push_back(mk(MODE_TRI, 3, 30, 0, 0));
    pending_cmds.push_back(mk(MODE_TRI, 3, 30, -128, 0));
    pending_cmds.push_back(mk(MODE_TRI, -4, 35, 127, 0));
    pending_cmds.push_back(mk(MODE_READ, 19, 39, 0, 0));
    pending_cmds.push_back(mk(MODE_SPARE_6, 1, 1, 1, 1));
    pending_cmds.push_back(mk(MODE_SPARE_7, 127, -128, 127, -128));
    pending_cmds.push_back(mk(MODE_READ, -128, 127, 0, 0));
    pending_cmds.push_back(mk(MODE_CLEAR, -1, -1, -1, -1));
    pending_cmds.push_back(mk(MODE_READ, 0, 0, 0, 0));
    repeat (725) pending_cmds.push_back(random_cmd());

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0 && !start && expected_pixels.size() == 0);
    // A read answers after its issue and result states; allow a little slack.
    repeat (20) @(posedge clk);

    $display("Covered %0d commands (clear %0d, rect %0d, line %0d, circle %0d, tri %0d).",
             n_cmds, mode_seen[MODE_CLEAR], mode_seen[MODE_RECT], mode_seen[MODE_LINE],
             mode_seen[MODE_CIRC], mode_seen[MODE_TRI]);
    $display("Checked %0d reads, %0d of them on drawn cells; %0d mismatches.",
             n_reads, n_lit, err_count);
    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("tb_bitmap_shape_rasterizer: clean");
    end else begin
      $display("tb_bitmap_shape_rasterizer: errors");
    end
    $finish;
  end

endmodule
